FILE: hdl/assert_macros.svh
// Assertion helpers for the file that checks this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks that a condition at one edge is followed by a property at the next.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: hdl/bae_pkg.sv
package bae_pkg;

    localparam int OP_W      = 2;
    localparam int AMOUNT_W  = 9;
    localparam int TARGET_W  = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int PCT_W     = 10;
    localparam int ERR_W     = 11;

    localparam int PERCENT_SCALE = 100;
    localparam int SPAN_COUNTS   = 993;
    localparam int PCT_MAX       = 511;
    localparam int PCT_MIN       = -512;

    localparam logic [TARGET_W-1:0] MAX_TARGET_RESET = 7'd100;
    localparam logic [TARGET_W-1:0] MIN_TARGET_RESET = 7'd0;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE  = 2'd0,
        OP_ADJUST  = 2'd1,
        OP_CAPTURE = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_TARGET = 1'b0,
        CFG_MIN_TARGET = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic                window_full;
        logic                reference_valid;
    } bae_status_t;

endpackage

FILE: hdl/boxcar_altitude_estimator.sv
// Boxcar altitude estimator. Each input beat is a new ADC sample, an adjust of the desired
// altitude, or a capture of the landed reference, and each produces exactly one output beat
// that reports the state after the update. The block takes one beat per clock cycle while the
// pipeline is not stalled; the window sum is a combinational add and subtract, and the oldest
// sample is read ahead into a register from a ring memory of DEPTH entries with one write port
// and one read port, so nothing in the loop limits that rate.
// After the window update, a result passes through four pipeline stages:
// the rounded means of the window and of the reference, their difference times 100, the
// division by the span of 993 counts, and the clamp and error subtraction. The ring needs
// no clearing pass after reset: until DEPTH samples have arrived, the samples leaving the
// window are read as zero. The target limits are written through the configuration port
// and are applied at the next adjust.
`include "assert_macros.svh"

module boxcar_altitude_estimator #(
    parameter int DEPTH       = 20,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bae_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bae_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [bae_pkg::OP_W-1:0]             operation,
    input  logic [SAMPLE_BITS-1:0]               sample,
    input  logic signed [bae_pkg::AMOUNT_W-1:0]  amount,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [SAMPLE_BITS-1:0]               mean_level,
    output logic signed [bae_pkg::PCT_W-1:0]     altitude_percent,
    output logic [bae_pkg::TARGET_W-1:0]         target_percent,
    output logic signed [bae_pkg::ERR_W-1:0]     altitude_error,
    output logic                                 window_full,
    output logic                                 reference_valid
);
    import bae_pkg::*;

    localparam int SUM_W = $clog2(DEPTH * ((1 << SAMPLE_BITS) - 1) + 1);

    logic [TARGET_W-1:0] max_target_reg, min_target_reg;
    logic                s1_valid, s1_ready;
    logic [SUM_W-1:0]    window_sum, ref_sum;
    bae_status_t         status;
    logic                adjust_beat, limits_ordered;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_target_reg <= MAX_TARGET_RESET;
            min_target_reg <= MIN_TARGET_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_TARGET: max_target_reg <= cfg_data;
                CFG_MIN_TARGET: min_target_reg <= cfg_data;
            endcase
        end
    end

    bae_window #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .sample     (sample),
        .amount     (amount),
        .max_target (max_target_reg),
        .min_target (min_target_reg),
        .s1_ready   (s1_ready),
        .s1_valid   (s1_valid),
        .window_sum (window_sum),
        .ref_sum    (ref_sum),
        .status     (status)
    );

    bae_scale #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_scale (
        .clk              (clk),
        .rst_n            (rst_n),
        .s1_valid         (s1_valid),
        .s1_ready         (s1_ready),
        .window_sum       (window_sum),
        .ref_sum          (ref_sum),
        .status           (status),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .mean_level       (mean_level),
        .altitude_percent (altitude_percent),
        .target_percent   (target_percent),
        .altitude_error   (altitude_error),
        .window_full      (window_full),
        .reference_valid  (reference_valid)
    );

    assign adjust_beat    = in_valid && !in_stall && (operation == OP_ADJUST);
    assign limits_ordered = (min_target_reg <= max_target_reg);

    `ASSERT_CLK(a_full_sticky, !$fell(status.window_full), "window full flag dropped")
    `ASSERT_CLK(a_ref_sticky, !$fell(status.reference_valid), "reference flag dropped")
    `ASSERT_NEXT(a_target_clamped, adjust_beat && limits_ordered, (status.target <= $past(max_target_reg)) && (status.target >= $past(min_target_reg)), "target outside limits")

endmodule

FILE: hdl/bae_mean.sv
module bae_mean #(
    parameter int DEPTH       = 20,
    parameter int SAMPLE_BITS = 12,
    parameter int SUM_W       = 17
) (
    input  logic [SUM_W-1:0]       window_sum,
    output logic [SAMPLE_BITS-1:0] mean
);
    import bae_pkg::*;

    // Rounded mean (2*sum + DEPTH) / (2*DEPTH) by multiplication with a
    // rounded-up reciprocal; the shift is wide enough to make it exact.
    localparam int DIV    = 2 * DEPTH;
    localparam int NUM_W  = $clog2(DIV * ((1 << SAMPLE_BITS) - 1) + DEPTH + 1);
    localparam int SHIFT  = NUM_W + $clog2(DIV);
    localparam int MULT_W = NUM_W + 2;
    localparam int PROD_W = NUM_W + MULT_W;
    localparam logic [MULT_W-1:0] MULT =
        MULT_W'(((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV));

    logic [NUM_W-1:0]  numer;
    logic [PROD_W-1:0] prod;

    assign numer = NUM_W'({window_sum, 1'b0}) + NUM_W'(DEPTH);
    assign prod  = PROD_W'(numer) * PROD_W'(MULT);
    assign mean  = prod[SHIFT +: SAMPLE_BITS];

endmodule

FILE: hdl/bae_window.sv
module bae_window #(
    parameter int DEPTH       = 20,
    parameter int SAMPLE_BITS = 12,
    parameter int SUM_W       = 17
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [bae_pkg::OP_W-1:0]             operation,
    input  logic [SAMPLE_BITS-1:0]               sample,
    input  logic signed [bae_pkg::AMOUNT_W-1:0]  amount,
    input  logic [bae_pkg::TARGET_W-1:0]         max_target,
    input  logic [bae_pkg::TARGET_W-1:0]         min_target,
    input  logic                                 s1_ready,
    output logic                                 s1_valid,
    output logic [SUM_W-1:0]                     window_sum,
    output logic [SUM_W-1:0]                     ref_sum,
    output bae_pkg::bae_status_t                 status
);
    import bae_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int TSUM_W = AMOUNT_W + 1;

    logic [SAMPLE_BITS-1:0] ring_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] old_data_reg;

    logic [PTR_W-1:0]    ptr_reg, ptr_next, ptr_inc, rd_addr;
    logic [FILL_W-1:0]   fill_reg, fill_next, fill_inc;
    logic [SUM_W-1:0]    sum_reg, sum_next, sum_new;
    logic [SUM_W-1:0]    ref_sum_reg, ref_sum_next;
    logic [TARGET_W-1:0] target_reg, target_next;
    logic                armed_reg, armed_next;
    logic                latched_reg, latched_next;
    logic                s1_valid_reg, s1_valid_next;

    logic                   accept, take_sample, is_full;
    logic [SAMPLE_BITS-1:0] oldest;
    logic signed [TSUM_W-1:0] t_sum;

    assign in_stall    = s1_valid_reg && !s1_ready;
    assign accept      = in_valid && !in_stall;
    assign take_sample = accept && (operation == OP_SAMPLE);
    assign is_full     = (fill_reg == FILL_W'(DEPTH));

    assign ptr_inc  = (ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign fill_inc = fill_reg + 1'b1;
    assign rd_addr  = take_sample ? ptr_inc : ptr_reg;

    // Entries not yet written are not reset but are read as zero, and the ring is
    // filled in pointer order, so the fill count tells when memory is valid.
    assign oldest  = is_full ? old_data_reg : '0;
    assign sum_new = sum_reg - SUM_W'(oldest) + SUM_W'(sample);
    assign t_sum   = $signed(TSUM_W'(target_reg)) + TSUM_W'(amount);

    always_comb
    begin
        ptr_next      = ptr_reg;
        fill_next     = fill_reg;
        sum_next      = sum_reg;
        ref_sum_next  = ref_sum_reg;
        target_next   = target_reg;
        armed_next    = armed_reg;
        latched_next  = latched_reg;
        s1_valid_next = accept || (s1_valid_reg && !s1_ready);
        if (accept)
        begin
            unique case (operation)
                OP_SAMPLE:
                begin
                    sum_next = sum_new;
                    ptr_next = ptr_inc;
                    if (!is_full)
                    begin
                        fill_next = fill_inc;
                        if ((fill_inc == FILL_W'(DEPTH)) && armed_reg)
                        begin
                            ref_sum_next = sum_new;
                            latched_next = 1'b1;
                            armed_next   = 1'b0;
                        end
                    end
                end
                OP_ADJUST:
                begin
                    priority if (t_sum > $signed(TSUM_W'(max_target)))
                        target_next = max_target;
                    else if (t_sum < $signed(TSUM_W'(min_target)))
                        target_next = min_target;
                    else
                        target_next = t_sum[TARGET_W-1:0];
                end
                OP_CAPTURE:
                begin
                    if (is_full)
                    begin
                        ref_sum_next = sum_reg;
                        latched_next = 1'b1;
                    end
                    else
                    begin
                        armed_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            fill_reg     <= '0;
            sum_reg      <= '0;
            ref_sum_reg  <= '0;
            target_reg   <= '0;
            armed_reg    <= 1'b0;
            latched_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg      <= ptr_next;
            fill_reg     <= fill_next;
            sum_reg      <= sum_next;
            ref_sum_reg  <= ref_sum_next;
            target_reg   <= target_next;
            armed_reg    <= armed_next;
            latched_reg  <= latched_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // The read addresses the slot that the next sample will overwrite, so the oldest entry
    // is ready in the register when the next sample arrives.
    always_ff @(posedge clk)
    begin
        if (take_sample)
            ring_mem[ptr_reg] <= sample;
        old_data_reg <= ring_mem[rd_addr];
    end

    assign s1_valid               = s1_valid_reg;
    assign window_sum             = sum_reg;
    assign ref_sum                = ref_sum_reg;
    assign status.target          = target_reg;
    assign status.window_full     = is_full;
    assign status.reference_valid = latched_reg;

endmodule

FILE: hdl/bae_scale.sv
module bae_scale #(
    parameter int DEPTH       = 20,
    parameter int SAMPLE_BITS = 12,
    parameter int SUM_W       = 17
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s1_valid,
    output logic                              s1_ready,
    input  logic [SUM_W-1:0]                  window_sum,
    input  logic [SUM_W-1:0]                  ref_sum,
    input  bae_pkg::bae_status_t              status,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [SAMPLE_BITS-1:0]            mean_level,
    output logic signed [bae_pkg::PCT_W-1:0]  altitude_percent,
    output logic [bae_pkg::TARGET_W-1:0]      target_percent,
    output logic signed [bae_pkg::ERR_W-1:0]  altitude_error,
    output logic                              window_full,
    output logic                              reference_valid
);
    import bae_pkg::*;

    localparam int DIFF_W    = SAMPLE_BITS + 1;
    localparam int MAG_W     = SAMPLE_BITS + 7;
    localparam int PROD_W    = MAG_W + 1;
    localparam int PCT_SHIFT = MAG_W + $clog2(SPAN_COUNTS);
    localparam int PMULT_W   = MAG_W + 2;
    localparam int QPROD_W   = MAG_W + PMULT_W;
    localparam int Q_W       = MAG_W - 9;
    localparam int EXT_W     = (Q_W + 1 > PCT_W + 1) ? Q_W + 1 : PCT_W + 1;
    localparam logic [PMULT_W-1:0] PCT_MULT =
        PMULT_W'(((64'd1 << PCT_SHIFT) + 64'(SPAN_COUNTS) - 64'd1) / 64'(SPAN_COUNTS));

    logic [SAMPLE_BITS-1:0] mean_now, ref_mean_now;

    logic                   v2_reg, v3_reg, v4_reg, v5_reg;
    logic                   r2, r3, r4, r5;
    logic [SAMPLE_BITS-1:0] mean2_reg, refm2_reg, mean3_reg, mean4_reg, mean5_reg;
    bae_status_t            st2_reg, st3_reg, st4_reg, st5_reg;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod3_next, prod3_reg;
    logic [PROD_W-1:0]        abs_full;
    logic [MAG_W-1:0]         mag;
    logic [QPROD_W-1:0]       qprod;
    logic [Q_W-1:0]           quot4_next, quot4_reg;
    logic                     neg4_reg;
    logic signed [EXT_W-1:0]  pct_mag, pct_wide;
    logic signed [PCT_W-1:0]  pct_next, pct_reg;
    logic signed [ERR_W-1:0]  err_next, err_reg;

    bae_mean #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_mean_live (
        .window_sum (window_sum),
        .mean       (mean_now)
    );

    bae_mean #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_mean_ref (
        .window_sum (ref_sum),
        .mean       (ref_mean_now)
    );

    assign r5       = !v5_reg || !out_stall;
    assign r4       = !v4_reg || r5;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign s1_ready = r2;

    assign diff       = $signed({1'b0, refm2_reg}) - $signed({1'b0, mean2_reg});
    assign prod3_next = PROD_W'(diff) * PROD_W'(PERCENT_SCALE);

    // Division by the span is done on the magnitude so that it truncates
    // toward zero; the sign is put back in the last stage.
    assign abs_full   = prod3_reg[PROD_W-1] ? PROD_W'(-prod3_reg) : PROD_W'(prod3_reg);
    assign mag        = abs_full[MAG_W-1:0];
    assign qprod      = QPROD_W'(mag) * QPROD_W'(PCT_MULT);
    assign quot4_next = qprod[PCT_SHIFT +: Q_W];

    assign pct_mag  = $signed(EXT_W'(quot4_reg));
    assign pct_wide = neg4_reg ? -pct_mag : pct_mag;

    always_comb
    begin
        priority if (pct_wide > EXT_W'(PCT_MAX))
            pct_next = PCT_W'(PCT_MAX);
        else if (pct_wide < EXT_W'(PCT_MIN))
            pct_next = PCT_W'(PCT_MIN);
        else
            pct_next = pct_wide[PCT_W-1:0];
    end

    assign err_next = ERR_W'($signed({1'b0, st4_reg.target})) - ERR_W'(pct_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (r2)
                v2_reg <= s1_valid;
            if (r3)
                v3_reg <= v2_reg;
            if (r4)
                v4_reg <= v3_reg;
            if (r5)
                v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r2)
        begin
            mean2_reg <= mean_now;
            refm2_reg <= ref_mean_now;
            st2_reg   <= status;
        end
        if (r3)
        begin
            mean3_reg <= mean2_reg;
            prod3_reg <= prod3_next;
            st3_reg   <= st2_reg;
        end
        if (r4)
        begin
            mean4_reg <= mean3_reg;
            quot4_reg <= quot4_next;
            neg4_reg  <= prod3_reg[PROD_W-1];
            st4_reg   <= st3_reg;
        end
        if (r5)
        begin
            mean5_reg <= mean4_reg;
            pct_reg   <= pct_next;
            err_reg   <= err_next;
            st5_reg   <= st4_reg;
        end
    end

    assign out_valid        = v5_reg;
    assign mean_level       = mean5_reg;
    assign altitude_percent = pct_reg;
    assign target_percent   = st5_reg.target;
    assign altitude_error   = err_reg;
    assign window_full      = st5_reg.window_full;
    assign reference_valid  = st5_reg.reference_valid;

endmodule
